@@ hdl/billboard_view_transform_clip_top_defines.svh @@
// Assertion macros used by the checker file of the billboard transform block.
`ifndef BILLBOARD_VIEW_TRANSFORM_CLIP_TOP_DEFINES_SVH
`define BILLBOARD_VIEW_TRANSFORM_CLIP_TOP_DEFINES_SVH

// Checks a consequent in the same cycle as the antecedent.
`define BVTC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequent in the cycle after the antecedent.
`define BVTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bvtc_pkg.sv @@
// Package with types and constants of the billboard view transform block.
package bvtc_pkg;

    localparam int SPRITE_COUNT_DEF = 16;
    localparam int VERTS = 5;
    localparam int SEL_W = 8;

    typedef enum logic [2:0] {
        REG_ROT_ONE    = 3'd0,
        REG_ROT_TWO    = 3'd1,
        REG_ROT_THREE  = 3'd2,
        REG_VIEWER_XY  = 3'd3,
        REG_VIEWER_Z   = 3'd4,
        REG_NEAR       = 3'd5,
        REG_FAR        = 3'd6,
        REG_INTERVAL   = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        VTX_CENTER = 3'd0,
        VTX_TL     = 3'd1,
        VTX_TR     = 3'd2,
        VTX_BR     = 3'd3,
        VTX_BL     = 3'd4
    } vtx_t;

    // Clamps a view coordinate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [40:0] x);
        logic signed [31:0] r;
        if (x > 41'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -41'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

@@ hdl/billboard_view_transform_clip_top.sv @@
// Top level of the billboard view transform and outcode clipping block.
//
//  channel | signals                        | direction
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_stall, particle   | one particle per item
//  out     | out_valid, out_stall, vertex   | five vertex items per particle
//  cfg     | cfg_valid, cfg_ready, index    | register writes, always ready
//
// A particle occupies the issue stage while it issues its vertices, one vertex
// a cycle unless the pipeline is held; the next particle is accepted as the last
// vertex issues. Vertices pass four arithmetic stages and are gathered in one of
// two banks; out_valid rises once the last vertex has been written to its bank.
// Reset clears all control state and the config registers; no clearing pass.
// A stall on the output holds the pipeline once stage 4 finds the fill bank full.
module billboard_view_transform_clip_top
    import bvtc_pkg::*;
#(
    parameter int SPRITE_COUNT = SPRITE_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [30:0]        sprite_size,
    input  logic [31:0]        age,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         vertex_index,
    output logic signed [31:0] view_x,
    output logic signed [31:0] view_y,
    output logic signed [31:0] view_z,
    output logic [5:0]         clip_flags,
    output logic               last,
    output logic               visible,
    output logic [7:0]         sprite_select,
    output logic               sprite_select_valid
);

    localparam logic [SEL_W:0] COUNT_LIM = (SEL_W+1)'(SPRITE_COUNT);

    // Configuration registers.
    logic [47:0]        rot_reg [3];
    logic signed [31:0] vw_reg [3];
    logic signed [31:0] near_reg;
    logic signed [31:0] far_reg;
    logic [31:0]        intv_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0] <= '0;
            rot_reg[1] <= '0;
            rot_reg[2] <= '0;
            vw_reg[0]  <= '0;
            vw_reg[1]  <= '0;
            vw_reg[2]  <= '0;
            near_reg   <= '0;
            far_reg    <= '0;
            intv_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROT_ONE:   rot_reg[0] <= cfg_data[47:0];
                REG_ROT_TWO:   rot_reg[1] <= cfg_data[47:0];
                REG_ROT_THREE: rot_reg[2] <= cfg_data[47:0];
                REG_VIEWER_XY:
                begin
                    vw_reg[0] <= cfg_data[31:0];
                    vw_reg[1] <= cfg_data[63:32];
                end
                REG_VIEWER_Z:  vw_reg[2] <= cfg_data[31:0];
                REG_NEAR:      near_reg <= cfg_data[31:0];
                REG_FAR:       far_reg <= cfg_data[31:0];
                REG_INTERVAL:  intv_reg <= cfg_data[31:0];
                default:       ;
            endcase
        end
    end

    logic signed [15:0] mat [3][3];
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                mat[r][c] = rot_reg[r][16*c +: 16];
    end

    // Pipeline advance: only the collector can hold the pipe.
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic full_reg [2];
    logic wb_reg;
    assign en = !(v4_reg && full_reg[wb_reg]);

    // Issue stage: holds the particle and steps through its vertices.
    logic               sq_valid_reg;
    logic [2:0]         cnt_reg;
    logic signed [31:0] p_reg [3];
    logic [30:0]        size_reg;
    logic [7:0]         age_reg;
    logic [31:0]        rem_reg;
    logic [SEL_W-1:0]   q_reg;
    logic               ovf_reg;
    logic               issue, take;

    assign issue    = en && sq_valid_reg;
    assign in_stall = sq_valid_reg && !(issue && cnt_reg == 3'(VTX_BL));
    assign take     = in_valid && !in_stall;

    // Two restoring division steps for every vertex before the last.
    logic [32:0] t0, t1;
    logic [31:0] rem_next;
    logic [1:0]  qb;
    always_comb
    begin
        t0 = {rem_reg, age_reg[{~cnt_reg[1:0], 1'b1}]};
        qb[1] = t0 >= {1'b0, intv_reg};
        if (qb[1])
            t0 = t0 - {1'b0, intv_reg};
        t1 = {t0[31:0], age_reg[{~cnt_reg[1:0], 1'b0}]};
        qb[0] = t1 >= {1'b0, intv_reg};
        if (qb[0])
            t1 = t1 - {1'b0, intv_reg};
        rem_next = t1[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (take)
        begin
            sq_valid_reg <= 1'b1;
            cnt_reg      <= '0;
        end
        else if (issue)
        begin
            if (cnt_reg == 3'(VTX_BL))
                sq_valid_reg <= 1'b0;
            cnt_reg <= cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p_reg[0] <= pos_x;
            p_reg[1] <= pos_y;
            p_reg[2] <= pos_z;
            size_reg <= sprite_size;
            age_reg  <= age[7:0];
            rem_reg  <= {8'd0, age[31:8]};
            ovf_reg  <= {8'd0, age[31:8]} >= intv_reg;
            q_reg    <= '0;
        end
        else if (issue && cnt_reg != 3'(VTX_BL))
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[SEL_W-3:0], qb};
        end
    end

    // Stage 1: corner offset times edge length.
    logic signed [17:0] off [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            case (vtx_t'(cnt_reg))
                VTX_TL:  off[k] = -18'(mat[0][k]) - 18'(mat[1][k]);
                VTX_TR:  off[k] = 18'(mat[0][k]) - 18'(mat[1][k]);
                VTX_BR:  off[k] = 18'(mat[0][k]) + 18'(mat[1][k]);
                VTX_BL:  off[k] = -18'(mat[0][k]) + 18'(mat[1][k]);
                default: off[k] = '0;
            endcase
        end
    end

    logic [2:0]         idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [SEL_W-1:0]   sel1_reg, sel2_reg, sel3_reg, sel4_reg;
    logic               sv1_reg, sv2_reg, sv3_reg, sv4_reg;
    logic signed [31:0] p1_reg [3];
    logic signed [49:0] prod1_reg [3];
    logic signed [36:0] d2_reg [3];
    logic signed [52:0] m3_reg [3][3];
    logic signed [31:0] vo4_reg [3];

    logic sel_ok;
    assign sel_ok = !ovf_reg && intv_reg != '0 && {1'b0, q_reg} < COUNT_LIM;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= sq_valid_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    logic signed [50:0] g [3];
    logic signed [54:0] acc [3];
    logic signed [40:0] rnd [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            g[k] = 51'(p1_reg[k]) * 51'sd32768 + 51'(prod1_reg[k]) + 51'sd16384;
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = 55'(m3_reg[r][0]) + 55'(m3_reg[r][1]) + 55'(m3_reg[r][2])
                   + 55'sd8192;
            rnd[r] = 41'(acc[r] >>> 14);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg <= cnt_reg;
            sel1_reg <= sel_ok ? q_reg : '0;
            sv1_reg  <= sel_ok;
            for (int k = 0; k < 3; k++)
            begin
                p1_reg[k]    <= p_reg[k];
                prod1_reg[k] <= 50'(off[k]) * 50'($signed({1'b0, size_reg}));
            end
            idx2_reg <= idx1_reg;
            sel2_reg <= sel1_reg;
            sv2_reg  <= sv1_reg;
            for (int k = 0; k < 3; k++)
                d2_reg[k] <= 37'(36'(g[k] >>> 15)) - 37'(vw_reg[k]);
            idx3_reg <= idx2_reg;
            sel3_reg <= sel2_reg;
            sv3_reg  <= sv2_reg;
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                    m3_reg[r][k] <= 53'(mat[r][k]) * 53'(d2_reg[k]);
            idx4_reg <= idx3_reg;
            sel4_reg <= sel3_reg;
            sv4_reg  <= sv3_reg;
            for (int r = 0; r < 3; r++)
                vo4_reg[r] <= sat32(rnd[r]);
        end
    end

    // Outcode of the vertex in stage 4.
    logic [5:0] code;
    logic signed [32:0] nz;
    always_comb
    begin
        nz = -33'(vo4_reg[2]);
        code = '0;
        if (vo4_reg[2] < near_reg)
            code[0] = 1'b1;
        else if (vo4_reg[2] > far_reg)
            code[1] = 1'b1;
        code[2] = vo4_reg[0] > vo4_reg[2];
        code[3] = 33'(vo4_reg[0]) < nz;
        code[4] = vo4_reg[1] > vo4_reg[2];
        code[5] = 33'(vo4_reg[1]) < nz;
    end

    // Collector: two banks of five vertices, one filling while one drains.
    logic signed [31:0] bx_reg [2][VERTS];
    logic signed [31:0] by_reg [2][VERTS];
    logic signed [31:0] bz_reg [2][VERTS];
    logic [5:0]         bc_reg [2][VERTS];
    logic               vis_reg [2];
    logic [SEL_W-1:0]   bsel_reg [2];
    logic               bsv_reg [2];
    logic [5:0]         andc_reg;
    logic               rb_reg;
    logic [2:0]         rs_reg;
    logic               wr, rd_done;

    assign wr      = v4_reg && !full_reg[wb_reg];
    assign rd_done = full_reg[rb_reg] && !out_stall && rs_reg == 3'(VTX_BL);

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            bx_reg[wb_reg][idx4_reg] <= vo4_reg[0];
            by_reg[wb_reg][idx4_reg] <= vo4_reg[1];
            bz_reg[wb_reg][idx4_reg] <= vo4_reg[2];
            bc_reg[wb_reg][idx4_reg] <= code;
            andc_reg <= (idx4_reg == 3'(VTX_CENTER)) ? code : (andc_reg & code);
            if (idx4_reg == 3'(VTX_BL))
            begin
                vis_reg[wb_reg]  <= (andc_reg & code) == '0;
                bsel_reg[wb_reg] <= sel4_reg;
                bsv_reg[wb_reg]  <= sv4_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg[0] <= 1'b0;
            full_reg[1] <= 1'b0;
            wb_reg      <= 1'b0;
            rb_reg      <= 1'b0;
            rs_reg      <= '0;
        end
        else
        begin
            if (wr && idx4_reg == 3'(VTX_BL))
            begin
                full_reg[wb_reg] <= 1'b1;
                wb_reg           <= !wb_reg;
            end
            if (full_reg[rb_reg] && !out_stall)
            begin
                if (rd_done)
                begin
                    full_reg[rb_reg] <= 1'b0;
                    rb_reg           <= !rb_reg;
                    rs_reg           <= '0;
                end
                else
                    rs_reg <= rs_reg + 3'd1;
            end
        end
    end

    assign out_valid           = full_reg[rb_reg];
    assign vertex_index        = rs_reg;
    assign view_x              = bx_reg[rb_reg][rs_reg];
    assign view_y              = by_reg[rb_reg][rs_reg];
    assign view_z              = bz_reg[rb_reg][rs_reg];
    assign clip_flags          = bc_reg[rb_reg][rs_reg];
    assign last                = rs_reg == 3'(VTX_BL);
    assign visible             = vis_reg[rb_reg];
    assign sprite_select       = bsel_reg[rb_reg];
    assign sprite_select_valid = bsv_reg[rb_reg];

endmodule

@@ hdl/bvtc_checker.sv @@
// Port-level checker for the billboard transform block and its bind.
`include "billboard_view_transform_clip_top_defines.svh"

module bvtc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] vertex_index,
    input logic       last,
    input logic       visible,
    input logic [7:0] sprite_select
);

    `BVTC_ASSERT_SAME(a_last_idx, out_valid, last == (vertex_index == 3'd4), "last mismatch")
    `BVTC_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(vertex_index), "held item changed")
    `BVTC_ASSERT_NEXT(a_seq, out_valid && !out_stall && !last, out_valid && vertex_index == $past(vertex_index) + 3'd1, "vertex order broken")
    `BVTC_ASSERT_NEXT(a_flags, out_valid && !out_stall && !last, $stable(visible) && $stable(sprite_select), "particle flags changed")
    `BVTC_ASSERT_NEXT(a_wrap, out_valid && !out_stall && last, !out_valid || vertex_index == 3'd0, "new particle not at centre")

endmodule

bind billboard_view_transform_clip_top bvtc_checker u_bvtc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .vertex_index  (vertex_index),
    .last          (last),
    .visible       (visible),
    .sprite_select (sprite_select)
);
